FILE: rtl/core/rfgp_pkg.sv
// rfgp_pkg: shared types, constants and codes for the rgb fade/gamma/pwm block
// no dependencies; used by rfgp_lane, rfgp_datapath, rfgp_ctrl and rgb_fade_gamma_pwm
package rfgp_pkg;

    // channel count and field widths
    localparam int NUM_CH     = 3;
    localparam int LEVEL_W    = 8;
    localparam int DUTY_W     = 16;
    localparam int STEPS_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // 255^3, full-scale value of the cubed level
    localparam logic [24:0] GAMMA_FULL_SCALE = 25'd16581375;

    // floor(2^48 / 255^3), reciprocal for the gamma divide
    localparam logic [24:0] GAMMA_RECIP = 25'd16975370;

    // blend divider length (quotient bits)
    localparam int BDIV_STEPS = 8;
    localparam int CNT_W      = $clog2(BDIV_STEPS);

    // register reset values
    localparam logic [STEPS_W-1:0] FADE_STEPS_RST = 8'd30;
    localparam logic [DUTY_W-1:0]  PWM_PERIOD_RST = 16'd1000;

    // request function codes
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 1'b1;

    // input request payload
    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_req;

    // result payload
    typedef struct packed {
        logic [DUTY_W-1:0]  duty_red;
        logic [DUTY_W-1:0]  duty_green;
        logic [DUTY_W-1:0]  duty_blue;
        logic [LEVEL_W-1:0] shown_red;
        logic [LEVEL_W-1:0] shown_green;
        logic [LEVEL_W-1:0] shown_blue;
    } t_rsp;

    // configuration write payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic set_load;
        logic mul_a;
        logic mul_b;
        logic bdiv_step;
        logic gsq;
        logic gcube;
        logic gscale;
        logic gest;
        logic gfix;
        logic commit;
    } t_cmd;

endpackage

FILE: rtl/core/rfgp_stream_if.sv
// rfgp_stream_if: valid/ready channel carrying one payload of type T
// depends on nothing; payload types come from rfgp_pkg at the instance
interface rfgp_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rfgp_lane.sv
// rfgp_lane: one color channel: fade blend, bit-serial divide, cube and gamma divide
// depends on rfgp_pkg
module rfgp_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rfgp_pkg::t_cmd                i_cmd,
    input  logic [rfgp_pkg::LEVEL_W-1:0]  i_color,
    input  logic [rfgp_pkg::STEPS_W-1:0]  i_steps,
    input  logic [rfgp_pkg::STEPS_W-1:0]  i_wa,
    input  logic [rfgp_pkg::STEPS_W-1:0]  i_wb,
    input  logic [rfgp_pkg::DUTY_W-1:0]   i_period,
    output logic [rfgp_pkg::LEVEL_W-1:0]  o_shown,
    output logic [rfgp_pkg::DUTY_W-1:0]   o_lit
);

    logic [7:0]  r_shown;
    logic [7:0]  r_origin;
    logic [7:0]  r_target;
    logic [15:0] r_acc;
    logic [7:0]  r_brem;
    logic [7:0]  r_bquo;
    logic [15:0] r_sq;
    logic [23:0] r_cube;
    logic [39:0] r_num;
    logic [15:0] r_gquo;

    logic [15:0] w_mul_a;
    logic [15:0] w_mul_b;
    logic [15:0] w_sum;
    logic [8:0]  w_btrial;
    logic        w_bge;
    logic [8:0]  w_bdiff;
    logic [15:0] w_sq;
    logic [23:0] w_cube;
    logic [39:0] w_num;
    logic [47:0] w_est;
    logic [39:0] w_back;
    logic [39:0] w_rem;
    logic        w_gfix;

    // blend products: origin weight then target weight
    assign w_mul_a = 16'(r_origin) * 16'(i_wa);
    assign w_mul_b = 16'(r_target) * 16'(i_wb);
    assign w_sum   = r_acc + w_mul_b;

    // restoring divide by step count, one quotient bit per cycle
    assign w_btrial = {r_brem, r_bquo[7]};
    assign w_bge    = w_btrial >= {1'b0, i_steps};
    assign w_bdiff  = w_btrial - {1'b0, i_steps};

    // gamma products
    assign w_sq   = 16'(r_bquo) * 16'(r_bquo);
    assign w_cube = 24'(r_sq) * 24'(r_shown);
    assign w_num  = 40'(i_period) * 40'(r_cube);

    // quotient estimate from the reciprocal of 255^3, low by at most one
    assign w_est = 48'(r_num[39:16]) * 48'(rfgp_pkg::GAMMA_RECIP);

    // remainder check bumps the estimate when it came out one low
    assign w_back = 40'(r_gquo) * 40'(rfgp_pkg::GAMMA_FULL_SCALE);
    assign w_rem  = r_num - w_back;
    assign w_gfix = w_rem >= 40'(rfgp_pkg::GAMMA_FULL_SCALE);

    // architectural color state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown  <= '0;
            r_origin <= '0;
            r_target <= '0;
        end else begin
            if (i_cmd.set_load) begin
                r_origin <= r_shown;
                r_target <= i_color;
            end
            if (i_cmd.gsq) begin
                r_shown <= r_bquo;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_acc <= w_mul_a;
        end
        if (i_cmd.mul_b) begin
            r_brem <= w_sum[15:8];
            r_bquo <= w_sum[7:0];
        end else if (i_cmd.bdiv_step) begin
            r_brem <= w_bge ? w_bdiff[7:0] : w_btrial[7:0];
            r_bquo <= {r_bquo[6:0], w_bge};
        end
        if (i_cmd.gsq) begin
            r_sq <= w_sq;
        end
        if (i_cmd.gcube) begin
            r_cube <= w_cube;
        end
        if (i_cmd.gscale) begin
            r_num <= w_num;
        end
        if (i_cmd.gest) begin
            r_gquo <= w_est[47:32];
        end else if (i_cmd.gfix) begin
            r_gquo <= r_gquo + 16'(w_gfix);
        end
    end

    assign o_shown = r_shown;
    assign o_lit   = r_gquo;

endmodule

FILE: rtl/core/rfgp_datapath.sv
// rfgp_datapath: step index, blend weights, three channel lanes and result register
// depends on rfgp_pkg and rfgp_lane
module rfgp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rfgp_pkg::t_cmd                i_cmd,
    input  rfgp_pkg::t_req                i_req,
    input  logic [rfgp_pkg::STEPS_W-1:0]  i_fade_steps,
    input  logic [rfgp_pkg::DUTY_W-1:0]   i_pwm_period,
    output rfgp_pkg::t_rsp                o_rsp
);

    logic [7:0]  r_step;
    rfgp_pkg::t_rsp r_rsp;

    logic [7:0]  w_steps;
    logic [7:0]  w_last;
    logic [7:0]  w_k;
    logic [7:0]  w_wa;
    logic [7:0]  w_wb;
    logic [7:0]  w_color [rfgp_pkg::NUM_CH];
    logic [7:0]  w_shown [rfgp_pkg::NUM_CH];
    logic [15:0] w_lit   [rfgp_pkg::NUM_CH];

    // effective step count and clamped step index
    assign w_steps = (i_fade_steps == '0) ? 8'd1 : i_fade_steps;
    assign w_last  = w_steps - 8'd1;
    assign w_k     = (r_step > w_last) ? w_last : r_step;
    assign w_wa    = w_last - w_k;
    assign w_wb    = w_k + 8'd1;

    assign w_color[0] = i_req.red;
    assign w_color[1] = i_req.green;
    assign w_color[2] = i_req.blue;

    // one lane per color channel
    for (genvar g = 0; g < rfgp_pkg::NUM_CH; g++) begin : g_lane
        rfgp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (i_cmd),
            .i_color  (w_color[g]),
            .i_steps  (w_steps),
            .i_wa     (w_wa),
            .i_wb     (w_wb),
            .i_period (i_pwm_period),
            .o_shown  (w_shown[g]),
            .o_lit    (w_lit[g])
        );
    end

    // step index: cleared by a set, advanced with saturation on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.set_load) begin
            r_step <= '0;
        end else if (i_cmd.commit) begin
            r_step <= (w_wb < w_steps) ? w_wb : w_k;
        end
    end

    // result register, inverted duty
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.duty_red    <= i_pwm_period - w_lit[0];
            r_rsp.duty_green  <= i_pwm_period - w_lit[1];
            r_rsp.duty_blue   <= i_pwm_period - w_lit[2];
            r_rsp.shown_red   <= w_shown[0];
            r_rsp.shown_green <= w_shown[1];
            r_rsp.shown_blue  <= w_shown[2];
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/core/rfgp_ctrl.sv
// rfgp_ctrl: sequencer for set and tick requests and result-valid flag
// depends on rfgp_pkg
module rfgp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_func,
    output logic           o_req_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rfgp_pkg::t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL_A  = 10'b0000000010,
        S_MUL_B  = 10'b0000000100,
        S_BDIV   = 10'b0000001000,
        S_GSQ    = 10'b0000010000,
        S_GCUBE  = 10'b0000100000,
        S_GSCALE = 10'b0001000000,
        S_GEST   = 10'b0010000000,
        S_GFIX   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [rfgp_pkg::CNT_W-1:0]  r_cnt;
    logic [rfgp_pkg::CNT_W-1:0]  n_cnt;
    logic                        r_out_valid;
    logic                        n_out_valid;
    rfgp_pkg::t_cmd              w_cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_func == rfgp_pkg::FUNC_SET) begin
                        w_cmd.set_load = 1'b1;
                    end else begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_MUL_A: begin
                w_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                w_cmd.mul_b = 1'b1;
                n_cnt       = '0;
                n_state     = S_BDIV;
            end
            S_BDIV: begin
                w_cmd.bdiv_step = 1'b1;
                if (r_cnt == rfgp_pkg::CNT_W'(rfgp_pkg::BDIV_STEPS - 1)) begin
                    n_state = S_GSQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_GSQ: begin
                w_cmd.gsq = 1'b1;
                n_state   = S_GCUBE;
            end
            S_GCUBE: begin
                w_cmd.gcube = 1'b1;
                n_state     = S_GSCALE;
            end
            S_GSCALE: begin
                w_cmd.gscale = 1'b1;
                n_state      = S_GEST;
            end
            S_GEST: begin
                w_cmd.gest = 1'b1;
                n_state    = S_GFIX;
            end
            S_GFIX: begin
                w_cmd.gfix = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the result register to be free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    a_cmd_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> r_out_valid)
        else $error("commit did not raise result valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before taken");

    a_bdiv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_B) |=> ((r_state == S_BDIV) && (r_cnt == '0)))
        else $error("blend divider did not start from a cleared count");

    a_set_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.set_load |=> (r_state == S_IDLE))
        else $error("set request left the idle state");
`endif

endmodule

FILE: rtl/core/rgb_fade_gamma_pwm.sv
// rgb_fade_gamma_pwm: a tick request runs the blend products, the 8-step blend divider and
// the gamma cube and reciprocal multiply with its correction before committing its result;
// a new request is taken only back in idle; a set request is handled in the idle state.
// the result register frees the input side while a result waits to be taken.
// reset is synchronous active low: colors and step index clear, fade_steps 30, period 1000.
// depends on rfgp_pkg, rfgp_stream_if, rfgp_ctrl, rfgp_datapath
module rgb_fade_gamma_pwm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfgp_stream_if.sink   i_req,
    rfgp_stream_if.source o_rsp,
    rfgp_stream_if.sink   i_cfg
);

    logic [rfgp_pkg::STEPS_W-1:0] r_fade_steps;
    logic [rfgp_pkg::DUTY_W-1:0]  r_pwm_period;
    rfgp_pkg::t_cmd               w_cmd;
    rfgp_pkg::t_req               w_req;
    rfgp_pkg::t_cfg               w_cfg;
    rfgp_pkg::t_rsp               w_rsp;
    logic                         w_req_ready;

    assign w_req = i_req.data;
    assign w_cfg = i_cfg.data;

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_steps <= rfgp_pkg::FADE_STEPS_RST;
            r_pwm_period <= rfgp_pkg::PWM_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (w_cfg.idx)
                rfgp_pkg::CFG_FADE_STEPS: r_fade_steps <= w_cfg.wdata[rfgp_pkg::STEPS_W-1:0];
                rfgp_pkg::CFG_PWM_PERIOD: r_pwm_period <= w_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    rfgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (w_req.func),
        .o_req_ready (w_req_ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    // arithmetic and state
    rfgp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req        (w_req),
        .i_fade_steps (r_fade_steps),
        .i_pwm_period (r_pwm_period),
        .o_rsp        (w_rsp)
    );

    assign o_rsp.data = w_rsp;

endmodule
